// ===== rtl/core/psch_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic message scheduler package
// Shared constants, codes and types for the scheduler core and its divider.
// ----------------------------------------------------------------------------
package psch_pkg;

   localparam int SLOT_COUNT   = 32;
   localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MAX_RESULTS  = 32;
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int DIV_W        = 32;
   localparam int DIV_CNT_W    = $clog2(DIV_W);

   localparam logic [31:0] US_PER_SECOND = 32'd1000000;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_ADD  = 2'd2;

   localparam logic [1:0] KIND_DUE    = 2'd0;
   localparam logic [1:0] KIND_PLACED = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic [15:0] message_id;
      logic [6:0]  function_code;
      logic [31:0] period_ticks;
      logic [31:0] tick_count;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  slot_number;
      logic [15:0] message_id;
      logic [6:0]  function_code;
   } result_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_EV,
      ST_ADD_RD,
      ST_ADD_EV,
      ST_ADD_DIV1,
      ST_ADD_DIV2,
      ST_FLUSH
   } sched_state_type;

endpackage

// ===== rtl/core/psch_div.sv =====
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with quotient.
// ----------------------------------------------------------------------------
module psch_div
   import psch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     rem_ff,   rem_in;
   logic [DIV_W-1:0]     quo_ff,   quo_in;
   logic [DIV_W-1:0]     dsr_ff,   dsr_in;
   logic [DIV_W:0]       trial;

   assign trial = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/periodic_message_scheduler.sv =====
// ----------------------------------------------------------------------------
// A load or unused opcode completes in the idle state. A tick reads and then
// evaluates every slot in turn, holding while a result waits on the output.
// An add scans the slots for a free one and, on finding it, runs one division
// (two for a nonzero rate) in one shared divider. One transaction at a time.
// Reset clears the table valid bits, the rate register and all control state.
// ----------------------------------------------------------------------------
// Periodic message scheduler
// Slot table of periodic commands; tick, load and add transactions.
// ----------------------------------------------------------------------------
module periodic_message_scheduler
   import psch_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] slot_index, [20:5] message_id, [27:21] function_code,
   // [59:28] period_value, [63:60] zero
   input  logic [63:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] slot_number, [20:5] due_message_id, [27:21] due_function_code,
   // [31:28] zero
   output logic [31:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);

   sched_state_type state_ff, state_in;

   slot_entry_type mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] vld_ff;
   slot_entry_type        rd_entry_ff;
   logic                  rd_vld_ff;
   slot_entry_type        ent;

   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_addr;
   slot_entry_type        mem_wdata;

   logic [19:0]           rate_ff;
   logic [SLOT_W-1:0]     slot_ff,   slot_in;
   logic [SLOT_W-1:0]     found_ff,  found_in;
   logic [15:0]           id_ff,     id_in;
   logic [6:0]            fc_ff,     fc_in;
   logic [31:0]           per_ff,    per_in;
   logic [RES_CNT_W-1:0]  rcnt_ff,   rcnt_in;
   logic                  pend_v_ff, pend_v_in;
   result_type            pend_ff,   pend_in;
   logic                  rsp_v_ff,  rsp_v_in;
   result_type            rsp_ff,    rsp_in;
   logic                  rsp_l_ff,  rsp_l_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  req_acc;
   logic                  rsp_free;
   logic                  last_slot;
   logic [SLOT_W-1:0]     req_slot;
   logic                  req_slot_ok;
   logic [15:0]           req_id;
   logic [6:0]            req_fc;
   logic [31:0]           req_per;
   logic [32:0]           cnt_inc;
   logic                  fire;
   logic                  rec;
   logic                  tick_stall;
   logic                  is_free;
   logic [31:0]           tick_us;

   assign req_slot    = SLOT_W'(req_tdata[4:0]);
   assign req_slot_ok = 32'(req_tdata[4:0]) < SLOT_COUNT;
   assign req_id      = req_tdata[20:5];
   assign req_fc      = req_tdata[27:21];
   assign req_per     = req_tdata[59:28];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_v_ff || rsp_tready;
   assign last_slot  = (slot_ff == SLOT_W'(SLOT_COUNT - 1));

   assign ent        = rd_vld_ff ? rd_entry_ff : '0;
   assign cnt_inc    = {1'b0, ent.tick_count} + 33'd1;
   assign fire       = (ent.period_ticks != '0) && (cnt_inc >= {1'b0, ent.period_ticks});
   assign rec        = rcnt_ff < RES_CNT_W'(MAX_RESULTS);
   assign tick_stall = fire && rec && pend_v_ff && !rsp_free;
   assign is_free    = (ent.period_ticks == '0) && (ent.message_id == '0);
   assign tick_us    = (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser == OP_TICK) begin
               state_in = ST_TICK_RD;
            end else if (req_acc && req_tuser == OP_ADD) begin
               state_in = ST_ADD_RD;
            end
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_EV;
         end
         ST_TICK_EV: begin
            if (!tick_stall) begin
               state_in = last_slot ? ST_FLUSH : ST_TICK_RD;
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_EV;
         end
         ST_ADD_EV: begin
            if (is_free) begin
               state_in = (rate_ff == '0) ? ST_ADD_DIV2 : ST_ADD_DIV1;
            end else if (last_slot) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_ADD_RD;
            end
         end
         ST_ADD_DIV1: begin
            if (div_rsp.done) begin
               state_in = ST_ADD_DIV2;
            end
         end
         ST_ADD_DIV2: begin
            if (div_rsp.done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      slot_in     = slot_ff;
      found_in    = found_ff;
      id_in       = id_ff;
      fc_in       = fc_ff;
      per_in      = per_ff;
      rcnt_in     = rcnt_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      rsp_v_in    = rsp_tready ? 1'b0 : rsp_v_ff;
      rsp_in      = rsp_ff;
      rsp_l_in    = rsp_l_ff;
      mem_we      = 1'b0;
      mem_addr    = slot_ff;
      mem_wdata   = ent;
      div_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            slot_in   = '0;
            rcnt_in   = '0;
            pend_v_in = 1'b0;
            id_in     = req_id;
            fc_in     = req_fc;
            per_in    = req_per;
            if (req_acc && req_tuser == OP_LOAD && req_slot_ok) begin
               mem_we                  = 1'b1;
               mem_addr                = req_slot;
               mem_wdata.message_id    = (req_per == '0) ? '0 : req_id;
               mem_wdata.function_code = (req_per == '0) ? '0 : req_fc;
               mem_wdata.period_ticks  = req_per;
               mem_wdata.tick_count    = '0;
            end
         end
         ST_TICK_RD: begin
         end
         ST_TICK_EV: begin
            if (!tick_stall) begin
               mem_we = (ent.period_ticks != '0);
               mem_wdata.tick_count = fire ? '0 : cnt_inc[31:0];
               if (fire && rec) begin
                  if (pend_v_ff) begin
                     rsp_v_in = 1'b1;
                     rsp_in   = pend_ff;
                     rsp_l_in = 1'b0;
                  end
                  pend_v_in             = 1'b1;
                  pend_in.kind          = KIND_DUE;
                  pend_in.slot_number   = 5'(slot_ff);
                  pend_in.message_id    = ent.message_id;
                  pend_in.function_code = ent.function_code;
                  rcnt_in               = rcnt_ff + 1'b1;
               end
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_ADD_RD: begin
         end
         ST_ADD_EV: begin
            if (is_free) begin
               found_in         = slot_ff;
               div_req.start    = (rate_ff != '0);
               div_req.dividend = (rate_ff == '0) ? per_ff : US_PER_SECOND;
               div_req.divisor  = (rate_ff == '0) ? US_PER_SECOND : {12'd0, rate_ff};
               if (rate_ff == '0) begin
                  div_req.start = 1'b1;
               end
            end else if (last_slot) begin
               pend_v_in             = 1'b1;
               pend_in.kind          = KIND_REJECT;
               pend_in.slot_number   = '0;
               pend_in.message_id    = id_ff;
               pend_in.function_code = fc_ff;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_ADD_DIV1: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = per_ff;
            div_req.divisor  = tick_us;
         end
         ST_ADD_DIV2: begin
            if (div_rsp.done) begin
               mem_we                  = 1'b1;
               mem_addr                = found_ff;
               mem_wdata.message_id    = id_ff;
               mem_wdata.function_code = fc_ff;
               mem_wdata.period_ticks  = div_rsp.quotient;
               mem_wdata.tick_count    = '0;
               pend_v_in               = 1'b1;
               pend_in.kind            = KIND_PLACED;
               pend_in.slot_number     = 5'(found_ff);
               pend_in.message_id      = id_ff;
               pend_in.function_code   = fc_ff;
            end
         end
         ST_FLUSH: begin
            if (pend_v_ff && rsp_free) begin
               rsp_v_in  = 1'b1;
               rsp_in    = pend_ff;
               rsp_l_in  = 1'b1;
               pend_v_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_entry_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         rate_ff   <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         rcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= vld_ff[slot_ff];
         if (mem_we) begin
            vld_ff[mem_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_data;
         end
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         rcnt_ff   <= rcnt_in;
      end
      slot_ff  <= slot_in;
      found_ff <= found_in;
      id_ff    <= id_in;
      fc_ff    <= fc_in;
      per_ff   <= per_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
      rsp_l_ff <= rsp_l_in;
   end

   psch_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_l_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.function_code, rsp_ff.message_id, rsp_ff.slot_number};

endmodule

// ===== rtl/core/psch_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic message scheduler checker
// Port-level properties of the scheduler, attached by bind.
// ----------------------------------------------------------------------------
module psch_checker
   import psch_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result transaction changed while stalled");

   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_TICK || req_tuser == OP_ADD)
      |=> !req_tready)
      else $error("tick or add transaction did not hold off the request side");

   a_add_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PLACED || rsp_tuser == KIND_REJECT) |-> rsp_tlast)
      else $error("add result not marked last");

   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_REJECT |-> rsp_tdata[4:0] == 5'd0)
      else $error("rejected add carries a slot number");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind periodic_message_scheduler psch_checker u_psch_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic message scheduler testbench
// Drives tick, load, add and unused transactions under several tick rates,
// predicts every due, placed and rejected result from a local copy of the
// slot table, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb
   import psch_pkg::*;
();

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         SETTLE_CYCLES = 2 * SLOT_COUNT + 96;
   localparam int         CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic       last;
      result_type res;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [19:0] csr_data = '0;

   // local copy of the slot table and rate register
   logic [15:0] table_id     [SLOT_COUNT];
   logic [6:0]  table_fc     [SLOT_COUNT];
   logic [31:0] table_period [SLOT_COUNT];
   logic [31:0] table_count  [SLOT_COUNT];
   logic [19:0] rate_hz = '0;

   sched_result_type pending_results[$];
   sched_result_type head;

   int errors        = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int adds_rejected = 0;
   int rate_writes   = 0;
   int hold_cycles   = 0;
   int cycle_count   = 0;
   bit steady        = 1'b0;

   periodic_message_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

   function automatic logic [31:0] tick_length();
      logic [31:0] q;
      if (rate_hz == '0) return US_PER_SECOND;
      q = US_PER_SECOND / {12'd0, rate_hz};
      return (q == '0) ? 32'd1 : q;
   endfunction

   task automatic advance_schedule(input logic [1:0] op, input logic [4:0] idx,
                                   input logic [15:0] id, input logic [6:0] fc,
                                   input logic [31:0] per);
      bit               fired[SLOT_COUNT];
      int               final_slot;
      int               free_slot;
      logic [32:0]      next_count;
      sched_result_type r;
      final_slot = -1;
      free_slot  = -1;
      case (op)
         OP_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               fired[i] = 1'b0;
               if (table_period[i] != '0) begin
                  next_count = {1'b0, table_count[i]} + 33'd1;
                  if (next_count >= {1'b0, table_period[i]}) begin
                     table_count[i] = '0;
                     fired[i]       = 1'b1;
                     final_slot     = i;
                  end else begin
                     table_count[i] = next_count[31:0];
                  end
               end
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (fired[i]) begin
                  r.res.kind          = KIND_DUE;
                  r.res.slot_number   = 5'(i);
                  r.res.message_id    = table_id[i];
                  r.res.function_code = table_fc[i];
                  r.last              = (i == final_slot);
                  pending_results     = {pending_results, r};
               end
            end
         end
         OP_LOAD: begin
            table_id[idx]     = (per == '0) ? 16'd0 : id;
            table_fc[idx]     = (per == '0) ? 7'd0 : fc;
            table_period[idx] = per;
            table_count[idx]  = '0;
         end
         OP_ADD: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (free_slot < 0 && table_period[i] == '0 && table_id[i] == '0)
                  free_slot = i;
            end
            r.res.message_id    = id;
            r.res.function_code = fc;
            r.last              = 1'b1;
            if (free_slot >= 0) begin
               table_id[free_slot]     = id;
               table_fc[free_slot]     = fc;
               table_period[free_slot] = per / tick_length();
               table_count[free_slot]  = '0;
               r.res.kind              = KIND_PLACED;
               r.res.slot_number       = 5'(free_slot);
            end else begin
               r.res.kind        = KIND_REJECT;
               r.res.slot_number = '0;
               adds_rejected++;
            end
            pending_results = {pending_results, r};
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                            input logic [15:0] id, input logic [6:0] fc,
                            input logic [31:0] per);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 5);
      @(negedge clock);
      while (gap > 0) begin
         req_tvalid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, per, fc, id, idx};
      do @(posedge clock); while (!req_tready);
      advance_schedule(op, idx, id, fc, per);
      items_sent++;
   endtask

   // drop valid, drain every expected result, then cover silent work
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [19:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      rate_hz = value;
      rate_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 9);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d slot %0d id %0d", rsp_tuser,
                   rsp_tdata[4:0], rsp_tdata[20:5]);
            errors++;
         end else begin
            head = pending_results.pop_front();
            check_field("result_kind", head.res.kind, rsp_tuser);
            check_field("slot_number", head.res.slot_number, rsp_tdata[4:0]);
            check_field("due_message_id", head.res.message_id, rsp_tdata[20:5]);
            check_field("due_function_code", head.res.function_code,
                        rsp_tdata[27:21]);
            check_field("last", head.last, rsp_tlast);
            results_seen++;
         end
      end
   end

   task automatic test_directed();
      write_rate(20'd0);
      send_item(OP_TICK, 5'd0, 16'd0, 7'd0, 32'd0);
      send_item(OP_ADD, 5'd31, 16'd1, 7'd0, 32'd3000000);
      send_item(OP_ADD, 5'd0, 16'hFFFF, 7'h7F, 32'd999999);
      send_item(OP_ADD, 5'd0, 16'd0, 7'h55, 32'd0);
      send_item(OP_ADD, 5'd0, 16'h1234, 7'h2A, 32'hFFFFFFFF);
      send_item(OP_LOAD, 5'd31, 16'hFFFF, 7'h7F, 32'd1);
      send_item(OP_LOAD, 5'd30, 16'd0, 7'd0, 32'd2);
      send_item(OP_LOAD, 5'd5, 16'hA5A5, 7'h2A, 32'hFFFFFFFF);
      send_item(OP_LOAD, 5'd5, 16'h5A5A, 7'h55, 32'd0);
      send_item(OP_UNUSED, 5'd31, 16'hFFFF, 7'h7F, 32'hFFFFFFFF);
      repeat (4) send_item(OP_TICK, 5'd31, 16'hFFFF, 7'h7F, 32'hFFFFFFFF);
      send_item(OP_LOAD, 5'd0, 16'h8001, 7'h40, 32'd1);
      send_item(OP_TICK, 5'd0, 16'd0, 7'd0, 32'd0);
      send_item(OP_ADD, 5'd0, 16'h0F0F, 7'h0F, 32'd5000000);
      send_item(OP_TICK, 5'd0, 16'd0, 7'd0, 32'd0);
      settle();
   endtask

   // fill every slot, overflow the receiver, then empty the table again
   task automatic test_full_table();
      for (int i = 0; i < SLOT_COUNT; i++)
         send_item(OP_LOAD, 5'(i), 16'($urandom), 7'($urandom), 32'd1);
      send_item(OP_ADD, 5'($urandom), 16'($urandom), 7'($urandom), 32'($urandom));
      hold_cycles = 400;
      repeat (4) send_item(OP_TICK, 5'($urandom), 16'($urandom), 7'($urandom),
                           32'($urandom));
      settle();
      for (int i = 0; i < SLOT_COUNT; i++)
         send_item(OP_LOAD, 5'(i), 16'($urandom), 7'($urandom), 32'd0);
      send_item(OP_ADD, 5'($urandom), 16'hC3C3, 7'h3C, 32'd0);
      settle();
   endtask

   task automatic test_random_traffic(input int count);
      int          pick;
      int          shape;
      logic [1:0]  op;
      logic [4:0]  idx;
      logic [15:0] id;
      logic [6:0]  fc;
      logic [31:0] per;
      for (int n = 0; n < count; n++) begin
         pick  = $urandom_range(0, 99);
         shape = $urandom_range(0, 99);
         idx   = 5'($urandom);
         id    = 16'($urandom);
         fc    = 7'($urandom);
         per   = $urandom;
         if (pick < 42) begin
            op = OP_TICK;
         end else if (pick < 75) begin
            op = OP_LOAD;
            if (shape < 35) per = '0;
            else if (shape < 85) per = $urandom_range(1, 6);
         end else if (pick < 97) begin
            op = OP_ADD;
            if (shape < 5) id = '0;
            if (shape >= 15)
               per = $urandom_range(0, 5) * tick_length()
                     + $urandom_range(0, tick_length() - 1);
         end else begin
            op = OP_UNUSED;
         end
         send_item(op, idx, id, fc, per);
      end
   endtask

   task automatic test_rate_sweep();
      logic [19:0] rates[6];
      rates = '{20'd1000, 20'd1, 20'hFFFFF, 20'd1000000,
                20'($urandom_range(2, 999999)), 20'd0};
      foreach (rates[k]) begin
         write_rate(rates[k]);
         steady = (k == 2);
         test_random_traffic(25);
         settle();
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         table_id[i]     = '0;
         table_fc[i]     = '0;
         table_period[i] = '0;
         table_count[i]  = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_rate_sweep();
      $display("Covered %0d transactions under %0d rate settings", items_sent,
               rate_writes);
      $display("Checked %0d results, %0d of them rejected adds", results_seen,
               adds_rejected);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/psch_pkg.sv
rtl/core/psch_div.sv
rtl/core/periodic_message_scheduler.sv
rtl/core/psch_checker.sv
tb/tb.sv
